// ===== rtl/smma_pkg.sv =====
// ----------------------------------------------------------------------------
// smma_pkg
// Shared types and constants for the sign-magnitude multiply-accumulate chain.
// ----------------------------------------------------------------------------
`default_nettype none

package smma_pkg;

  typedef enum logic [1:0] {
    OP_MUL     = 2'd0,
    OP_MAC     = 2'd1,
    OP_MAC_DIV = 2'd2
  } op_t;

  localparam int MAG_W     = 7;
  localparam int PROD_W    = 2 * MAG_W;
  localparam int MUL_STEPS = MAG_W;
  localparam int DIV_STEPS = 8;
  localparam logic [7:0] DIVISOR = 8'd96;

  // Beat moving through the multiply cells
  typedef struct packed {
    logic [1:0]        op;
    logic              sgn;
    logic [PROD_W-1:0] mcand;
    logic [MAG_W-1:0]  mplier;
    logic [PROD_W-1:0] prod;
    logic [7:0]        acc_high;
    logic [7:0]        acc_low;
  } mul_t;

  // Beat moving through the divide cells
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] rem;
    logic [7:0] quo;
  } div_t;

endpackage

`default_nettype wire

// ===== rtl/sign_magnitude_multiply_accumulate.sv =====
// ----------------------------------------------------------------------------
// sign_magnitude_multiply_accumulate
// Pipelined sign-magnitude multiply, multiply-add and multiply-add-divide.
// ----------------------------------------------------------------------------
// Takes one beat per cycle while the output is not stalled and returns one
// result beat per input beat, in order. The result passes through the cell
// chain: seven shift-add multiply cells, one
// sign-magnitude add stage and eight restoring divide cells, each with its
// own register and local ready, so bubbles close up behind a stalled output.
// Operation code 3 returns zero in both bytes.
`default_nettype none

module sign_magnitude_multiply_accumulate (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] operation,
  input  wire logic [7:0] multiplicand,
  input  wire logic [7:0] multiplier,
  input  wire logic [7:0] acc_high,
  input  wire logic [7:0] acc_low,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      result_high,
  output logic [7:0]      result_low
);

  smma_pkg::mul_t mul_data  [smma_pkg::MUL_STEPS+1];
  logic           mul_valid [smma_pkg::MUL_STEPS+1];
  logic           mul_ready [smma_pkg::MUL_STEPS+1];
  smma_pkg::div_t div_data  [smma_pkg::DIV_STEPS+1];
  logic           div_valid [smma_pkg::DIV_STEPS+1];
  logic           div_ready [smma_pkg::DIV_STEPS+1];
  smma_pkg::div_t last;
  smma_pkg::mul_t seed;

  // seed the multiply chain; a zero multiplier magnitude gives plus zero
  always_comb begin
    seed.op       = operation;
    seed.sgn      = (multiplicand[7] ^ multiplier[7] ^
                     (operation == smma_pkg::OP_MAC_DIV)) &&
                    (multiplier[6:0] != 7'd0);
    seed.mcand    = {{smma_pkg::MAG_W{1'b0}}, multiplicand[6:0]};
    seed.mplier   = multiplier[6:0];
    seed.prod     = '0;
    seed.acc_high = acc_high;
    seed.acc_low  = acc_low;
  end

  assign mul_data[0]  = seed;
  assign mul_valid[0] = in_valid;
  assign in_ready     = mul_ready[0];

  for (genvar i = 0; i < smma_pkg::MUL_STEPS; i++) begin : g_mul
    smma_mul_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (mul_valid[i]),
      .up_ready (mul_ready[i]),
      .up_data  (mul_data[i]),
      .dn_valid (mul_valid[i+1]),
      .dn_ready (mul_ready[i+1]),
      .dn_data  (mul_data[i+1])
    );
  end

  smma_add_stage u_add (
    .clk      (clk),
    .rst      (rst),
    .up_valid (mul_valid[smma_pkg::MUL_STEPS]),
    .up_ready (mul_ready[smma_pkg::MUL_STEPS]),
    .up_data  (mul_data[smma_pkg::MUL_STEPS]),
    .dn_valid (div_valid[0]),
    .dn_ready (div_ready[0]),
    .dn_data  (div_data[0])
  );

  for (genvar j = 0; j < smma_pkg::DIV_STEPS; j++) begin : g_div
    smma_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (div_valid[j]),
      .up_ready (div_ready[j]),
      .up_data  (div_data[j]),
      .dn_valid (div_valid[j+1]),
      .dn_ready (div_ready[j+1]),
      .dn_data  (div_data[j+1])
    );
  end

  assign last                             = div_data[smma_pkg::DIV_STEPS];
  assign out_valid                        = div_valid[smma_pkg::DIV_STEPS];
  assign div_ready[smma_pkg::DIV_STEPS]   = out_ready;

  always_comb begin
    case (last.op)
      smma_pkg::OP_MAC_DIV: begin
        result_high = last.quo | {last.hi[7], 7'b0};
        result_low  = 8'd0;
      end
      default: begin
        result_high = last.hi;
        result_low  = last.lo;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/smma_mul_cell.sv =====
// ----------------------------------------------------------------------------
// smma_mul_cell
// One shift-add step of the magnitude multiply, with a one-beat register.
// ----------------------------------------------------------------------------
`default_nettype none

module smma_mul_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          up_valid,
  output logic               up_ready,
  input  wire smma_pkg::mul_t up_data,
  output logic               dn_valid,
  input  wire logic          dn_ready,
  output smma_pkg::mul_t     dn_data
);

  logic           valid;
  smma_pkg::mul_t data;
  smma_pkg::mul_t data_next;

  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_data  = data;

  always_comb begin
    data_next        = up_data;
    // add the shifted multiplicand when the low multiplier bit is set
    if (up_data.mplier[0]) begin
      data_next.prod = up_data.prod + up_data.mcand;
    end
    data_next.mcand  = {up_data.mcand[smma_pkg::PROD_W-2:0], 1'b0};
    data_next.mplier = {1'b0, up_data.mplier[smma_pkg::MAG_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/smma_add_stage.sv =====
// ----------------------------------------------------------------------------
// smma_add_stage
// Sign-magnitude add of product and accumulator (product alone for multiply, zero for code 3); seeds the divide chain.
// ----------------------------------------------------------------------------
`default_nettype none

module smma_add_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          up_valid,
  output logic               up_ready,
  input  wire smma_pkg::mul_t up_data,
  output logic               dn_valid,
  input  wire logic          dn_ready,
  output smma_pkg::div_t     dn_data
);

  logic           valid;
  smma_pkg::div_t data;
  smma_pkg::div_t data_next;

  logic [7:0] ph;
  logic [7:0] pl;
  logic [7:0] s;
  logic [7:0] r;
  logic [8:0] sl;
  logic [7:0] sh;
  logic       borrow;
  logic [7:0] l;
  logic [7:0] h;
  logic       under;
  logic [8:0] nl;
  logic [7:0] nh;
  logic [7:0] sum_hi;
  logic [7:0] sum_lo;

  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_data  = data;

  always_comb begin
    ph = {up_data.sgn, 1'b0, up_data.prod[smma_pkg::PROD_W-1:8]};
    pl = up_data.prod[7:0];
    s  = up_data.acc_high;
    r  = up_data.acc_low;

    // same signs
    sl = {1'b0, r} + {1'b0, pl};
    sh = s + ph + {7'b0, sl[8]};

    // different signs: magnitude difference, negate on underflow
    borrow = pl < r;
    l      = pl - r;
    h      = {1'b0, ph[6:0]} - {1'b0, s[6:0]} - {7'b0, borrow};
    under  = {1'b0, ph[6:0]} < ({1'b0, s[6:0]} + {7'b0, borrow});
    nl     = {1'b0, ~l} + 9'd1;
    nh     = 8'd0 - h - {7'b0, ~nl[8]};

    if (ph[7] == s[7]) begin
      sum_hi = sh | {ph[7], 7'b0};
      sum_lo = sl[7:0];
    end else if (under) begin
      sum_hi = {1'b1, nh[6:0]} ^ {ph[7], 7'b0};
      sum_lo = nl[7:0];
    end else begin
      sum_hi = h ^ {ph[7], 7'b0};
      sum_lo = l;
    end

    data_next.op = up_data.op;
    case (up_data.op) inside
      smma_pkg::OP_MUL: begin
        data_next.hi = ph;
        data_next.lo = pl;
      end
      smma_pkg::OP_MAC, smma_pkg::OP_MAC_DIV: begin
        data_next.hi = sum_hi;
        data_next.lo = sum_lo;
      end
      default: begin
        data_next.hi = 8'd0;
        data_next.lo = 8'd0;
      end
    endcase
    data_next.rem = {1'b0, data_next.hi[6:0]};
    data_next.quo = 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/smma_div_cell.sv =====
// ----------------------------------------------------------------------------
// smma_div_cell
// One restoring divide step by the fixed divisor, with a one-beat register.
// ----------------------------------------------------------------------------
`default_nettype none

module smma_div_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          up_valid,
  output logic               up_ready,
  input  wire smma_pkg::div_t up_data,
  output logic               dn_valid,
  input  wire logic          dn_ready,
  output smma_pkg::div_t     dn_data
);

  logic           valid;
  smma_pkg::div_t data;
  smma_pkg::div_t data_next;
  logic [7:0]     shifted;
  logic           qbit;

  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_data  = data;

  always_comb begin
    shifted       = {up_data.rem[6:0], 1'b0};
    qbit          = shifted >= smma_pkg::DIVISOR;
    data_next     = up_data;
    data_next.rem = qbit ? (shifted - smma_pkg::DIVISOR) : shifted;
    data_next.quo = {up_data.quo[6:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ===== bench/sign_magnitude_multiply_accumulate_test.sv =====
// ----------------------------------------------------------------------------
// sign_magnitude_multiply_accumulate_test
// Self-checking bench for the sign-magnitude multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
// Drives operand beats with random gaps and random output stalls. Each
// accepted beat is scored by an in-bench model of the sign-magnitude
// arithmetic, and each returned beat is compared in order against it.
`default_nettype none

module sign_magnitude_multiply_accumulate_test;
  timeunit 1ns;
  timeprecision 1ps;

  import smma_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_PCT = 27;
  localparam int DRAIN_CYCLES = 24;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] operation = '0;
  logic [7:0] multiplicand = '0;
  logic [7:0] multiplier = '0;
  logic [7:0] acc_high = '0;
  logic [7:0] acc_low = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] result_high;
  logic [7:0] result_low;

  logic [15:0] expected_results[$];
  int          mismatch_count = 0;
  bit          steady = 1'b0;

  always #10 clk = ~clk;

  sign_magnitude_multiply_accumulate dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .multiplicand (multiplicand),
    .multiplier   (multiplier),
    .acc_high     (acc_high),
    .acc_low      (acc_low),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_high  (result_high),
    .result_low   (result_low)
  );

  // Signed product: sign in bit 15, bit 14 zero, 14-bit magnitude below
  function automatic logic [15:0] sm_multiply(logic [7:0] a, logic [7:0] q);
    logic [13:0] prod;
    if (q[6:0] == 7'd0) return 16'h0000;
    prod = a[6:0] * q[6:0];
    return {a[7] ^ q[7], 1'b0, prod[13:8], prod[7:0]};
  endfunction

  function automatic logic [15:0] sm_accumulate(logic [15:0] p, logic [7:0] s,
                                                logic [7:0] r);
    logic [7:0] ph, pl, h, l;
    logic       sgn, borrow;
    logic [8:0] sum_lo, neg_lo;
    logic [7:0] sum_hi;
    ph = p[15:8];
    pl = p[7:0];
    sgn = ph[7];
    if (sgn == s[7]) begin
      // sign bits ride along in the high-byte add, then OR the sign back on
      sum_lo = {1'b0, r} + {1'b0, pl};
      sum_hi = s + ph + {7'b0, sum_lo[8]};
      return {sum_hi | {sgn, 7'b0}, sum_lo[7:0]};
    end
    borrow = pl < r;
    l = pl - r;
    h = {1'b0, ph[6:0]} - {1'b0, s[6:0]} - {7'b0, borrow};
    if ({1'b0, ph[6:0]} < {1'b0, s[6:0]} + {7'b0, borrow}) begin
      // negate the 16-bit difference and flag it negative
      neg_lo = {1'b0, ~l} + 9'd1;
      h = 8'd0 - h - {7'b0, ~neg_lo[8]};
      l = neg_lo[7:0];
      h = h | 8'h80;
    end
    return {h ^ {sgn, 7'b0}, l};
  endfunction

  function automatic logic [7:0] scale_by_96(logic [7:0] v);
    logic [7:0] rem, quo;
    rem = {1'b0, v[6:0]};
    quo = 8'd0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      rem = rem << 1;
      if (rem >= DIVISOR) begin
        rem = rem - DIVISOR;
        quo = {quo[6:0], 1'b1};
      end else begin
        quo = {quo[6:0], 1'b0};
      end
    end
    return quo | {v[7], 7'b0};
  endfunction

  function automatic logic [15:0] predict_mac(logic [1:0] op, logic [7:0] a,
                                              logic [7:0] q, logic [7:0] s,
                                              logic [7:0] r);
    logic [15:0] acc;
    case (op)
      OP_MUL: return sm_multiply(a, q);
      OP_MAC: return sm_accumulate(sm_multiply(a, q), s, r);
      OP_MAC_DIV: begin
        acc = sm_accumulate(sm_multiply(a ^ 8'h80, q), s, r);
        return {scale_by_96(acc[15:8]), 8'h00};
      end
      default: return 16'h0000;
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'h7F;
      2: return 8'h80;
      3: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [1:0] pick_op();
    int roll;
    roll = $urandom_range(99);
    if (roll < 30) return OP_MUL;
    if (roll < 60) return OP_MAC;
    if (roll < 95) return OP_MAC_DIV;
    return OP_UNUSED;
  endfunction

  task automatic send_beat(input logic [1:0] op, input logic [7:0] a,
                           input logic [7:0] q, input logic [7:0] s,
                           input logic [7:0] r);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    multiplicand <= a;
    multiplier   <= q;
    acc_high     <= s;
    acc_low      <= r;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_mac(op, a, q, s, r));
  endtask

  // Hold the input idle until every outstanding beat has returned
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic test_directed();
    send_beat(OP_MUL, 8'h00, 8'h00, 8'h00, 8'h00);
    send_beat(OP_MUL, 8'hFF, 8'hFF, 8'h00, 8'h00);
    send_beat(OP_MUL, 8'h7F, 8'hFF, 8'hFF, 8'hFF);
    // zero multiplier magnitude gives plus zero whatever the signs
    send_beat(OP_MUL, 8'hFF, 8'h80, 8'h00, 8'h00);
    send_beat(OP_MUL, 8'h85, 8'h00, 8'h00, 8'h00);
    send_beat(OP_MUL, 8'h80, 8'h81, 8'h00, 8'h00);
    // equal signs, carry out of the low byte and high-byte wrap
    send_beat(OP_MAC, 8'h7F, 8'h7F, 8'h7F, 8'hFF);
    send_beat(OP_MAC, 8'hFF, 8'h7F, 8'hFF, 8'hFF);
    send_beat(OP_MAC, 8'h01, 8'h01, 8'h00, 8'hFF);
    // different signs, no borrow
    send_beat(OP_MAC, 8'h7F, 8'h7F, 8'h80, 8'h01);
    // different signs, borrow from the low byte only with the result negated, and equal magnitudes
    send_beat(OP_MAC, 8'h00, 8'h00, 8'h80, 8'h05);
    send_beat(OP_MAC, 8'h02, 8'h03, 8'h80, 8'h06);
    send_beat(OP_MAC, 8'h82, 8'h03, 8'h00, 8'h07);
    // different signs, high-byte borrow; then a zero product, which adds as plus
    send_beat(OP_MAC, 8'h01, 8'h01, 8'hFF, 8'hFF);
    send_beat(OP_MAC, 8'h80, 8'h80, 8'h7F, 8'h00);
    // multiply-add-divide across the quotient range
    send_beat(OP_MAC_DIV, 8'h00, 8'h00, 8'h00, 8'h00);
    send_beat(OP_MAC_DIV, 8'h80, 8'h7F, 8'h7F, 8'hFF);
    send_beat(OP_MAC_DIV, 8'h7F, 8'h7F, 8'hFF, 8'hFF);
    send_beat(OP_MAC_DIV, 8'h00, 8'h7F, 8'h60, 8'h00);
    send_beat(OP_MAC_DIV, 8'hFF, 8'hFF, 8'h00, 8'h00);
    send_beat(OP_MAC_DIV, 8'h01, 8'h01, 8'hFF, 8'h00);
    // unused code returns zero
    send_beat(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_beat(OP_UNUSED, 8'h12, 8'h34, 8'h56, 8'h78);
  endtask

  task automatic test_random_mix(input int count);
    for (int i = 0; i < count; i++) begin
      steady = (i >= count / 3) && (i < count / 2);
      send_beat(pick_op(), pick_byte(), pick_byte(), pick_byte(), pick_byte());
    end
    steady = 1'b0;
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 12; i++)
      send_beat(pick_op(), pick_byte(), pick_byte(), pick_byte(), pick_byte());
    wait_for_results();
    for (int i = 0; i < 12; i++)
      send_beat(pick_op(), pick_byte(), pick_byte(), pick_byte(), pick_byte());
  endtask

  always @(posedge clk) begin : score_results
    logic [15:0] want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h_%h",
                 $realtime, result_high, result_low);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (result_high !== want[15:8]) begin
          $display("%0t: result_high expected %h actual %h",
                   $realtime, want[15:8], result_high);
          mismatch_count++;
        end
        if (result_low !== want[7:0]) begin
          $display("%0t: result_low expected %h actual %h",
                   $realtime, want[7:0], result_low);
          mismatch_count++;
        end
      end
    end
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_mix(950);
    test_drain_pause();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/smma_pkg.sv
rtl/smma_mul_cell.sv
rtl/smma_add_stage.sv
rtl/smma_div_cell.sv
rtl/sign_magnitude_multiply_accumulate.sv
bench/sign_magnitude_multiply_accumulate_test.sv
